>>> design/parametric_line_rect_clipper_unit_macros.svh
// assertion macros used by the line clipper checker
`ifndef PARAMETRIC_LINE_RECT_CLIPPER_UNIT_MACROS_SVH
`define PARAMETRIC_LINE_RECT_CLIPPER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock
`define LRC_ASSERT_IMPL(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock
`define LRC_ASSERT_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lrc_pkg.sv
// types and constants of the line/rectangle clipper
`default_nettype none
package lrc_pkg;

   localparam int COORD_W   = 24;
   localparam int SIZE_W    = 23;
   localparam int DIFF_W    = 25;
   localparam int QNUM_W    = 26;
   localparam int T_W       = 32;
   localparam int NUM_LANES = 4;
   localparam int MID_DEPTH = 8;
   localparam int OUT_DEPTH = 2;

   localparam int LANE_X_ENTER = 0;
   localparam int LANE_X_EXIT  = 1;
   localparam int LANE_Y_ENTER = 2;
   localparam int LANE_Y_EXIT  = 3;

   localparam logic signed [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [T_W-1:0] T_POS_INF = {1'b0, {(T_W-1){1'b1}}};
   localparam logic signed [T_W-1:0] T_FIN_MAX = {1'b0, {(T_W-2){1'b1}}, 1'b0};
   localparam logic signed [T_W-1:0] T_FIN_MIN = {1'b1, {(T_W-2){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      CSR_CLIP_LEFT,
      CSR_CLIP_TOP,
      CSR_CLIP_WIDTH,
      CSR_CLIP_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
   } lrc_clip_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic                      extend_back;
      logic                      extend_forward;
   } lrc_req_type;

   typedef struct packed {
      logic [QNUM_W-1:0] num_mag;
      logic              neg;
      logic              ovf;
   } lrc_lane_type;

   typedef struct packed {
      logic neg;
      logic ovf;
   } lrc_lane_flag_type;

   typedef struct packed {
      lrc_lane_type [NUM_LANES-1:0] lane;
      logic [DIFF_W-1:0]            den_x;
      logic [DIFF_W-1:0]            den_y;
      logic                         use_x;
      logic                         use_y;
      logic                         miss;
      logic                         extend_back;
      logic                         extend_forward;
   } lrc_item_type;

   typedef struct packed {
      lrc_lane_flag_type [NUM_LANES-1:0] lane;
      logic                              use_x;
      logic                              use_y;
      logic                              miss;
      logic                              extend_back;
      logic                              extend_forward;
   } lrc_side_type;

   typedef struct packed {
      logic                  hit;
      logic signed [T_W-1:0] t_enter;
      logic signed [T_W-1:0] t_exit;
   } lrc_result_type;

endpackage
`default_nettype wire

>>> design/lrc_fifo.sv
// small register queue with occupancy count
`default_nettype none
module lrc_fifo import lrc_pkg::*; #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [W-1:0]               push_data,
   input  wire logic                       pop,
   output logic      [W-1:0]               pop_data,
   output logic      [$clog2(DEPTH+1)-1:0] count,
   output logic                            empty,
   output logic                            full
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign count    = cnt_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

>>> design/lrc_front.sv
// front end: boundary distances, parallel test, lane setup
`default_nettype none
module lrc_front import lrc_pkg::*; #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire lrc_req_type  in_req,
   input  wire lrc_clip_type clip,
   output logic              out_valid,
   output lrc_item_type      out_item,
   output logic [1:0]        busy
);
   localparam int OVF_SHIFT = T_W - PARAM_FRAC_BITS;
   localparam int OVF_W     = DIFF_W + T_W;

   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [QNUM_W-1:0] s1_ql_ff, s1_qr_ff, s1_qt_ff, s1_qb_ff;
   logic signed [QNUM_W-1:0] s1_ql_in, s1_qr_in, s1_qt_in, s1_qb_in;
   logic                     s1_back_ff, s1_fwd_ff;
   logic                     s2_valid_ff;
   lrc_item_type             s2_item_ff, s2_item_in;

   logic              dx_zero, dy_zero, dx_pos, dy_pos;
   logic [DIFF_W-1:0] dx_mag, dy_mag;

   function automatic lrc_lane_type make_lane(input logic signed [QNUM_W-1:0] q,
                                              input logic [DIFF_W-1:0] den,
                                              input logic p_neg);
      lrc_lane_type r;
      logic [OVF_W-1:0] wide_num, wide_den;
      r.num_mag = q[QNUM_W-1] ? QNUM_W'(-q) : QNUM_W'(q);
      r.neg     = q[QNUM_W-1] ^ p_neg;
      wide_num  = OVF_W'(r.num_mag);
      wide_den  = OVF_W'(den) << OVF_SHIFT;
      r.ovf     = (wide_num >= wide_den);
      return r;
   endfunction

   always_comb begin
      s1_dx_in = DIFF_W'(in_req.end_x) - DIFF_W'(in_req.start_x);
      s1_dy_in = DIFF_W'(in_req.end_y) - DIFF_W'(in_req.start_y);
      s1_ql_in = QNUM_W'(in_req.start_x) - QNUM_W'(clip.left);
      s1_qr_in = QNUM_W'(clip.left) + QNUM_W'(signed'({1'b0, clip.width}))
                 - QNUM_W'(in_req.start_x);
      s1_qt_in = QNUM_W'(in_req.start_y) - QNUM_W'(clip.top);
      s1_qb_in = QNUM_W'(clip.top) + QNUM_W'(signed'({1'b0, clip.height}))
                 - QNUM_W'(in_req.start_y);
   end

   // p of the first boundary of a pair is -d: positive d enters there
   always_comb begin
      dx_zero = (s1_dx_ff == '0);
      dy_zero = (s1_dy_ff == '0);
      dx_pos  = !dx_zero && !s1_dx_ff[DIFF_W-1];
      dy_pos  = !dy_zero && !s1_dy_ff[DIFF_W-1];
      dx_mag  = s1_dx_ff[DIFF_W-1] ? DIFF_W'(-s1_dx_ff) : DIFF_W'(s1_dx_ff);
      dy_mag  = s1_dy_ff[DIFF_W-1] ? DIFF_W'(-s1_dy_ff) : DIFF_W'(s1_dy_ff);

      s2_item_in.lane[LANE_X_ENTER] = make_lane(dx_pos ? s1_ql_ff : s1_qr_ff, dx_mag, 1'b1);
      s2_item_in.lane[LANE_X_EXIT]  = make_lane(dx_pos ? s1_qr_ff : s1_ql_ff, dx_mag, 1'b0);
      s2_item_in.lane[LANE_Y_ENTER] = make_lane(dy_pos ? s1_qt_ff : s1_qb_ff, dy_mag, 1'b1);
      s2_item_in.lane[LANE_Y_EXIT]  = make_lane(dy_pos ? s1_qb_ff : s1_qt_ff, dy_mag, 1'b0);
      s2_item_in.den_x          = dx_mag;
      s2_item_in.den_y          = dy_mag;
      s2_item_in.use_x          = !dx_zero;
      s2_item_in.use_y          = !dy_zero;
      s2_item_in.miss           = (dx_zero && (s1_ql_ff[QNUM_W-1] || s1_qr_ff[QNUM_W-1]))
                               || (dy_zero && (s1_qt_ff[QNUM_W-1] || s1_qb_ff[QNUM_W-1]));
      s2_item_in.extend_back    = s1_back_ff;
      s2_item_in.extend_forward = s1_fwd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s1_ql_ff   <= s1_ql_in;
      s1_qr_ff   <= s1_qr_in;
      s1_qt_ff   <= s1_qt_in;
      s1_qb_ff   <= s1_qb_in;
      s1_back_ff <= in_req.extend_back;
      s1_fwd_ff  <= in_req.extend_forward;
      s2_item_ff <= s2_item_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;
   assign busy      = 2'(s1_valid_ff) + 2'(s2_valid_ff);
endmodule
`default_nettype wire

>>> design/lrc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lrc_div import lrc_pkg::*; #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 25,
   parameter int QUO_W = 32
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);
   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [NUM_W-1:0] rem_src [QUO_W];
   logic [DEN_W-1:0] den_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];
   logic [NUM_W-1:0] rem_in  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic [CMP_W-1:0] wide_rem, wide_den;
      logic             take;

      if (s == 0) begin : g_first
         assign rem_src[s] = num;
         assign den_src[s] = den;
         assign quo_src[s] = '0;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign den_src[s] = den_ff[s-1];
         assign quo_src[s] = quo_ff[s-1];
      end

      always_comb begin
         wide_rem = CMP_W'(rem_src[s]);
         wide_den = CMP_W'(den_src[s]) << BIT;
         take     = (wide_rem >= wide_den);
         rem_in[s] = take ? NUM_W'(wide_rem - wide_den) : rem_src[s];
         quo_in[s] = quo_src[s];
         quo_in[s][BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];
endmodule
`default_nettype wire

>>> design/lrc_back.sv
// back end: four lane dividers, saturation, interval narrowing
`default_nettype none
module lrc_back import lrc_pkg::*; #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire lrc_item_type item,
   output logic              item_pop,
   input  wire logic         res_room,
   output logic              res_push,
   output lrc_result_type    res
);
   localparam int NUM_W = QNUM_W + PARAM_FRAC_BITS;
   localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << PARAM_FRAC_BITS;

   logic                  en;
   logic [T_W-1:0]        quo [NUM_LANES];
   logic                  valid_ff [T_W];
   lrc_side_type          side_ff  [T_W];
   lrc_side_type          side_in;
   logic                  sat_valid_ff;
   lrc_side_type          sat_side_ff;
   logic signed [T_W-1:0] sat_t_ff [NUM_LANES];
   logic signed [T_W-1:0] sat_t_in [NUM_LANES];
   logic                  comb_valid_ff;
   logic signed [T_W-1:0] enter_ff, exit_ff, enter_in, exit_in;

   function automatic logic signed [T_W-1:0] saturate(input logic [T_W-1:0] mag,
                                                      input lrc_lane_flag_type f);
      logic signed [T_W-1:0] t;
      if (!f.neg) begin
         t = (f.ovf || mag > T_FIN_MAX) ? T_FIN_MAX : signed'(mag);
      end else begin
         t = (f.ovf || mag[T_W-1]) ? T_FIN_MIN : -signed'(mag);
      end
      return t;
   endfunction

   // the whole back end holds while a finished result cannot be handed on
   assign en       = !(comb_valid_ff && !res_room);
   assign item_pop = en && item_valid;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      lrc_div #(
         .NUM_W (NUM_W),
         .DEN_W (DIFF_W),
         .QUO_W (T_W)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   ({item.lane[l].num_mag, {PARAM_FRAC_BITS{1'b0}}}),
         .den   ((l < 2) ? item.den_x : item.den_y),
         .quo   (quo[l])
      );
      assign side_in.lane[l].neg = item.lane[l].neg;
      assign side_in.lane[l].ovf = item.lane[l].ovf;
      assign sat_t_in[l]         = saturate(quo[l], side_ff[T_W-1].lane[l]);
   end

   assign side_in.use_x          = item.use_x;
   assign side_in.use_y          = item.use_y;
   assign side_in.miss           = item.miss;
   assign side_in.extend_back    = item.extend_back;
   assign side_in.extend_forward = item.extend_forward;

   always_comb begin
      enter_in = sat_side_ff.extend_back ? T_NEG_INF : '0;
      exit_in  = sat_side_ff.extend_forward ? T_POS_INF : T_ONE;
      if (sat_side_ff.use_x && sat_t_ff[LANE_X_ENTER] > enter_in) begin
         enter_in = sat_t_ff[LANE_X_ENTER];
      end
      if (sat_side_ff.use_y && sat_t_ff[LANE_Y_ENTER] > enter_in) begin
         enter_in = sat_t_ff[LANE_Y_ENTER];
      end
      if (sat_side_ff.use_x && sat_t_ff[LANE_X_EXIT] < exit_in) begin
         exit_in = sat_t_ff[LANE_X_EXIT];
      end
      if (sat_side_ff.use_y && sat_t_ff[LANE_Y_EXIT] < exit_in) begin
         exit_in = sat_t_ff[LANE_Y_EXIT];
      end
      if (sat_side_ff.miss) begin
         enter_in = '0;
         exit_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < T_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
         sat_valid_ff  <= 1'b0;
         comb_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= item_pop;
         for (int s = 1; s < T_W; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         sat_valid_ff  <= valid_ff[T_W-1];
         comb_valid_ff <= sat_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < T_W; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         sat_side_ff <= side_ff[T_W-1];
         for (int l = 0; l < NUM_LANES; l++) begin
            sat_t_ff[l] <= sat_t_in[l];
         end
         enter_ff <= enter_in;
         exit_ff  <= exit_in;
      end
   end

   assign res_push    = comb_valid_ff && res_room;
   assign res.hit     = (enter_ff < exit_ff);
   assign res.t_enter = enter_ff;
   assign res.t_exit  = exit_ff;
endmodule
`default_nettype wire

>>> design/parametric_line_rect_clipper_unit.sv
// Liang-Barsky line clipper against a rectangle held in registers.
// Requests: push with the two endpoints (signed Q16.8) and the two extend
// flags; a transfer happens when push is high and full is low.
// Responses: while rsp_empty is low the oldest result (hit, t_enter,
// t_exit in signed Q16.16) is on the rsp_ ports; pop takes it.
// Clip rectangle: csr_we writes csr_wdata into register csr_index
// (0 left, 1 top, 2 width, 3 height); the user must write it only while
// the unit is idle, which the unit itself does not enforce.
// Throughput: one line per cycle while results are popped in time. A
// request passes two setup stages, the mid queue, 32 divider stages (one
// quotient bit each), saturation and narrowing stages, and the result queue.
// When pop stays low the result queue fills, the divider pipeline holds,
// the mid queue fills and full rises; nothing is dropped.
// Reset (synchronous, active high) clears the clip registers to zero and
// empties every queue and stage.
`default_nettype none
module parametric_line_rect_clipper_unit import lrc_pkg::*; #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   input  wire logic                      req_extend_back,
   input  wire logic                      req_extend_forward,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic                           rsp_hit,
   output logic signed [T_W-1:0]          rsp_t_enter,
   output logic signed [T_W-1:0]          rsp_t_exit,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [COORD_W-1:0]        csr_wdata
);
   localparam int MID_CNT_W = $clog2(MID_DEPTH+1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);
   localparam int CRED_W    = MID_CNT_W + 1;

   lrc_clip_type          clip_ff;
   lrc_req_type           req;
   logic                  req_accept;
   logic                  front_valid;
   lrc_item_type          front_item;
   logic [1:0]            front_busy;
   logic [$bits(lrc_item_type)-1:0] mid_data;
   lrc_item_type          mid_item;
   logic [MID_CNT_W-1:0]  mid_count;
   logic                  mid_empty, mid_full;
   logic                  back_pop;
   logic                  res_push;
   lrc_result_type        res;
   logic [$bits(lrc_result_type)-1:0] out_data;
   lrc_result_type        out_res;
   logic [OUT_CNT_W-1:0]  out_count;
   logic                  out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:   clip_ff.left   <= signed'(csr_wdata);
            CSR_CLIP_TOP:    clip_ff.top    <= signed'(csr_wdata);
            CSR_CLIP_WIDTH:  clip_ff.width  <= csr_wdata[SIZE_W-1:0];
            CSR_CLIP_HEIGHT: clip_ff.height <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // every item in the front stages already owns a mid queue slot
   assign req_full = (CRED_W'(mid_count) + CRED_W'(front_busy)) >= CRED_W'(MID_DEPTH);
   assign req_accept = req_push && !req_full;

   assign req.start_x        = req_start_x;
   assign req.start_y        = req_start_y;
   assign req.end_x          = req_end_x;
   assign req.end_y          = req_end_y;
   assign req.extend_back    = req_extend_back;
   assign req.extend_forward = req_extend_forward;

   lrc_front #(
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_req    (req),
      .clip      (clip_ff),
      .out_valid (front_valid),
      .out_item  (front_item),
      .busy      (front_busy)
   );

   lrc_fifo #(
      .W     ($bits(lrc_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .pop       (back_pop),
      .pop_data  (mid_data),
      .count     (mid_count),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   assign mid_item = lrc_item_type'(mid_data);

   lrc_back #(
      .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty && !mid_full || !mid_empty),
      .item       (mid_item),
      .item_pop   (back_pop),
      .res_room   (!out_full),
      .res_push   (res_push),
      .res        (res)
   );

   lrc_fifo #(
      .W     ($bits(lrc_result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .count     (out_count),
      .empty     (rsp_empty),
      .full      (out_full)
   );

   assign out_res     = lrc_result_type'(out_data);
   assign rsp_hit     = out_res.hit && (out_count != '0);
   assign rsp_t_enter = out_res.t_enter;
   assign rsp_t_exit  = out_res.t_exit;
endmodule
`default_nettype wire

>>> design/lrc_checker.sv
// port-level checks of the line clipper, bound to the top level
`default_nettype none
`include "parametric_line_rect_clipper_unit_macros.svh"
module lrc_checker import lrc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire logic                  rsp_hit,
   input wire logic signed [T_W-1:0] rsp_t_enter,
   input wire logic signed [T_W-1:0] rsp_t_exit
);
   // a waiting result stays put until its transfer
   `LRC_ASSERT_NEXT(a_rsp_hold, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_hit) && $stable(rsp_t_enter) && $stable(rsp_t_exit), "response changed while stalled")

   `LRC_ASSERT_IMPL(a_hit_order, reset, !rsp_empty && rsp_hit, rsp_t_enter < rsp_t_exit, "hit without entry below exit")

   // entry never reaches plus infinity and exit never minus infinity
   `LRC_ASSERT_IMPL(a_inf_side, reset, !rsp_empty, rsp_t_enter != T_POS_INF && rsp_t_exit != T_NEG_INF, "infinity code on the wrong side")

   `LRC_ASSERT_NEXT(a_reset_empty, 1'b0, reset, rsp_empty, "responses pending after reset")
endmodule

bind parametric_line_rect_clipper_unit lrc_checker u_lrc_checker (.*);
`default_nettype wire
